// ----- design/chs_pkg.sv -----
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package chs_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_ENTRIES         = 24;

   // Field widths
   localparam int SAMPLE_W = 13;
   localparam int DECL_W   = 12;
   localparam int DEG_W    = 9;
   localparam int SECTOR_W = 4;

   // Datapath widths: samples scaled by 256, plus CORDIC gain headroom
   localparam int SCALE_SHIFT = 8;
   localparam int XY_W        = 24;
   localparam int Z_W         = 18;

   // Angle constants in 1/256 degree, sums in 1/2560 degree
   localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(46080);
   localparam int FULL_TURN  = 921600;
   localparam int TOTAL_W    = 22;
   localparam int WRAP1_W    = 21;
   localparam int WRAP_W     = 20;
   localparam logic [TOTAL_W-1:0] TWO_TURNS = TOTAL_W'(2 * FULL_TURN);
   localparam logic [WRAP1_W-1:0] ONE_TURN  = WRAP1_W'(FULL_TURN);

   // Divide by 2560: drop 9 bits, then multiply by a reciprocal of 5
   localparam int DIV512_SHIFT = 9;
   localparam int QUOT_W       = WRAP_W - DIV512_SHIFT;
   localparam int DEG_RECIP_W  = 13;
   localparam int DEG_RECIP_SH = 15;
   localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = DEG_RECIP_W'(6554);

   // Divide by 30 for the sector index
   localparam int SEC_RECIP_W  = 12;
   localparam int SEC_RECIP_SH = 16;
   localparam logic [SEC_RECIP_W-1:0] SEC_RECIP = SEC_RECIP_W'(2185);
   localparam logic [DEG_W-1:0] DEG_FULL        = DEG_W'(360);
   localparam logic [DEG_W-1:0] DEG_LAST_SECTOR = DEG_W'(330);
   localparam logic [SECTOR_W-1:0] SECTOR_NONE  = SECTOR_W'(11);

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_DECLINATION = 1'b0;
   localparam logic signed [DECL_W-1:0] DECL_RESET = DECL_W'(-296);

   typedef struct packed {
      logic                   zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_beat_type;

   // round(atan(2^-i) * 256 * 180 / pi)
   function automatic logic signed [Z_W-1:0] atan_angle(input int idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         0:  a = Z_W'(11520);
         1:  a = Z_W'(6801);
         2:  a = Z_W'(3593);
         3:  a = Z_W'(1824);
         4:  a = Z_W'(916);
         5:  a = Z_W'(458);
         6:  a = Z_W'(229);
         7:  a = Z_W'(115);
         8:  a = Z_W'(57);
         9:  a = Z_W'(29);
         10: a = Z_W'(14);
         11: a = Z_W'(7);
         12: a = Z_W'(4);
         13: a = Z_W'(2);
         14: a = Z_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- design/chs_cordic_step.sv -----
// One registered CORDIC vectoring iteration with a fixed shift.
// Depends on chs_pkg for the beat type and the arctangent table.
`default_nettype none

module chs_cordic_step #(
   parameter int STEP = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    valid_in,
   input  wire chs_pkg::cordic_beat_type beat_in,
   output logic                         valid_out,
   output chs_pkg::cordic_beat_type     beat_out
);

   localparam logic signed [chs_pkg::Z_W-1:0] ANGLE = chs_pkg::atan_angle(STEP);

   logic                      valid_ff;
   chs_pkg::cordic_beat_type  beat_ff;
   chs_pkg::cordic_beat_type  beat_in_c;
   logic signed [chs_pkg::XY_W-1:0] xs;
   logic signed [chs_pkg::XY_W-1:0] ys;

   always_comb begin
      xs = beat_in.x >>> STEP;
      ys = beat_in.y >>> STEP;
      beat_in_c = beat_in;
      // rotate toward the x axis
      if (!beat_in.y[chs_pkg::XY_W-1]) begin
         beat_in_c.x = beat_in.x + ys;
         beat_in_c.y = beat_in.y - xs;
         beat_in_c.z = beat_in.z + ANGLE;
      end else begin
         beat_in_c.x = beat_in.x - ys;
         beat_in_c.y = beat_in.y + xs;
         beat_in_c.z = beat_in.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in_c;
   end

   assign valid_out = valid_ff;
   assign beat_out  = beat_ff;

endmodule

`default_nettype wire

// ----- design/chs_heading_post.sv -----
// Post-processing pipeline: declination add, turn wrap, degrees and sector index.
// Depends on chs_pkg for widths and reciprocal constants.
`default_nettype none

module chs_heading_post (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  valid_in,
   input  wire logic                                  zero_in,
   input  wire logic signed [chs_pkg::Z_W-1:0]        angle_in,
   input  wire logic signed [chs_pkg::DECL_W-1:0]     decl_in,
   output logic                                       strobe_out,
   output logic [chs_pkg::DEG_W-1:0]                  heading_out,
   output logic [chs_pkg::SECTOR_W-1:0]               sector_out
);

   localparam int SUM_W   = chs_pkg::TOTAL_W + 1;
   localparam int DPROD_W = chs_pkg::QUOT_W + chs_pkg::DEG_RECIP_W;
   localparam int SPROD_W = chs_pkg::DEG_W + chs_pkg::SEC_RECIP_W;

   logic [4:0] valid_ff;

   logic [chs_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [chs_pkg::WRAP1_W-1:0]  wrap1_ff, wrap1_in;
   logic [chs_pkg::WRAP_W-1:0]   wrap2_ff, wrap2_in;
   logic [chs_pkg::DEG_W-1:0]    deg_ff, deg_in;
   logic [chs_pkg::DEG_W-1:0]    heading_ff;
   logic [chs_pkg::SECTOR_W-1:0] sector_ff, sector_in;

   logic signed [SUM_W-1:0]  angle_ext;
   logic signed [SUM_W-1:0]  decl_ext;
   logic signed [SUM_W-1:0]  sum;
   logic [DPROD_W-1:0]       deg_prod;
   logic [chs_pkg::DEG_W-1:0] deg_m1;
   logic [SPROD_W-1:0]       sec_prod;

   always_comb begin
      // a zero vector has no bearing; count it as angle 0
      angle_ext = zero_in ? '0 : SUM_W'(angle_in);
      decl_ext  = SUM_W'(decl_in);
      // offset by two turns so the sum is never negative
      sum = (angle_ext <<< 3) + (angle_ext <<< 1) + (decl_ext <<< 8)
            + SUM_W'(chs_pkg::TWO_TURNS);
      total_in = sum[chs_pkg::TOTAL_W-1:0];

      if (total_ff >= chs_pkg::TWO_TURNS) begin
         wrap1_in = chs_pkg::WRAP1_W'(total_ff - chs_pkg::TWO_TURNS);
      end else begin
         wrap1_in = chs_pkg::WRAP1_W'(total_ff);
      end

      if (wrap1_ff >= chs_pkg::ONE_TURN) begin
         wrap2_in = chs_pkg::WRAP_W'(wrap1_ff - chs_pkg::ONE_TURN);
      end else begin
         wrap2_in = chs_pkg::WRAP_W'(wrap1_ff);
      end

      deg_prod = DPROD_W'(wrap2_ff[chs_pkg::WRAP_W-1:chs_pkg::DIV512_SHIFT])
                 * DPROD_W'(chs_pkg::DEG_RECIP);
      deg_in = deg_prod[chs_pkg::DEG_RECIP_SH +: chs_pkg::DEG_W];

      deg_m1   = deg_ff - chs_pkg::DEG_W'(1);
      sec_prod = SPROD_W'(deg_m1) * SPROD_W'(chs_pkg::SEC_RECIP);
      if (deg_ff != '0 && deg_ff <= chs_pkg::DEG_LAST_SECTOR) begin
         sector_in = sec_prod[chs_pkg::SEC_RECIP_SH +: chs_pkg::SECTOR_W];
      end else begin
         sector_in = chs_pkg::SECTOR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      wrap1_ff   <= wrap1_in;
      wrap2_ff   <= wrap2_in;
      deg_ff     <= deg_in;
      heading_ff <= deg_ff;
      sector_ff  <= sector_in;
   end

   assign strobe_out  = valid_ff[4];
   assign heading_out = heading_ff;
   assign sector_out  = sector_ff;

endmodule

`default_nettype wire

// ----- design/compass_heading_sector_top.sv -----
// Top level of the compass heading block: pre-rotation, CORDIC pipeline, post-processing, CSR.
// Depends on chs_pkg, chs_cordic_step and chs_heading_post.
`default_nettype none

// Compass heading and LED sector from one X/Y magnetometer sample.
// Input: drive req_x_field / req_y_field and pulse start; the beat is taken
// at a rising edge with start high. busy stays low: the pipeline takes a new
// beat every cycle, so throughput is one sample per clock.
// Output: rsp_strobe is high for one cycle with rsp_heading_degrees (0..359)
// and rsp_sector_index (0..11). The receiver cannot hold results off, and
// none needs to: every beat leaves exactly CORDIC_STEPS + 6 cycles after it
// was taken (22 at the default of 16 steps), in order. The figure is one
// register for the pre-rotation, one per CORDIC iteration, and five for the
// declination add, the two turn-wrap compares, the divide to degrees and
// the sector lookup.
// Configuration: APB register 0 (byte address 0) holds the signed
// declination in tenths of a degree; write it while no beat is in flight.
// Reset: synchronous, clears all in-flight beats and sets the declination
// to -29.6 degrees.
module compass_heading_sector_top #(
   parameter int CORDIC_STEPS = chs_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [chs_pkg::SAMPLE_W-1:0]  req_x_field,
   input  wire logic signed [chs_pkg::SAMPLE_W-1:0]  req_y_field,
   output logic                                      rsp_strobe,
   output logic [chs_pkg::DEG_W-1:0]                 rsp_heading_degrees,
   output logic [chs_pkg::SECTOR_W-1:0]              rsp_sector_index,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [chs_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [chs_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [chs_pkg::CSR_DATA_W-1:0]            prdata,
   output logic                                      pready
);

   localparam int PIPE_DEPTH = CORDIC_STEPS + 6;

   logic signed [chs_pkg::DECL_W-1:0] decl_ff;
   logic                              csr_write;
   logic                              csr_hit;

   logic                              pre_valid_ff;
   chs_pkg::cordic_beat_type          pre_beat_ff, pre_beat_in;
   logic signed [chs_pkg::XY_W-1:0]   x_scaled, y_scaled;

   logic                              stage_valid [0:CORDIC_STEPS];
   chs_pkg::cordic_beat_type          stage_beat  [0:CORDIC_STEPS];

   // ---- configuration port ----
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == chs_pkg::REG_DECLINATION);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         decl_ff <= chs_pkg::DECL_RESET;
      end else if (csr_write) begin
         decl_ff <= pwdata[chs_pkg::DECL_W-1:0];
      end
   end

   always_comb begin
      if (csr_hit) begin
         prdata = chs_pkg::CSR_DATA_W'(decl_ff);
      end else begin
         prdata = '0;
      end
   end

   // ---- pre-rotation into the right half plane ----
   assign busy = 1'b0;

   always_comb begin
      x_scaled = chs_pkg::XY_W'(req_x_field) <<< chs_pkg::SCALE_SHIFT;
      y_scaled = chs_pkg::XY_W'(req_y_field) <<< chs_pkg::SCALE_SHIFT;
      pre_beat_in.zero = (req_x_field == '0) && (req_y_field == '0);
      if (x_scaled[chs_pkg::XY_W-1]) begin
         pre_beat_in.x = -x_scaled;
         pre_beat_in.y = -y_scaled;
         pre_beat_in.z = y_scaled[chs_pkg::XY_W-1] ? -chs_pkg::HALF_TURN_Z
                                                   : chs_pkg::HALF_TURN_Z;
      end else begin
         pre_beat_in.x = x_scaled;
         pre_beat_in.y = y_scaled;
         pre_beat_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      pre_beat_ff <= pre_beat_in;
   end

   assign stage_valid[0] = pre_valid_ff;
   assign stage_beat[0]  = pre_beat_ff;

   // ---- CORDIC iterations, one register stage each ----
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      chs_cordic_step #(
         .STEP (i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stage_valid[i]),
         .beat_in   (stage_beat[i]),
         .valid_out (stage_valid[i+1]),
         .beat_out  (stage_beat[i+1])
      );
   end

   // ---- declination, wrap, degrees, sector ----
   chs_heading_post u_post (
      .clock       (clock),
      .reset       (reset),
      .valid_in    (stage_valid[CORDIC_STEPS]),
      .zero_in     (stage_beat[CORDIC_STEPS].zero),
      .angle_in    (stage_beat[CORDIC_STEPS].z),
      .decl_in     (decl_ff),
      .strobe_out  (rsp_strobe),
      .heading_out (rsp_heading_degrees),
      .sector_out  (rsp_sector_index)
   );

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_strobe)
      else $error("accepted beat did not produce a result on time");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_heading_degrees < chs_pkg::DEG_FULL))
      else $error("heading out of range");

   a_north_sector: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_heading_degrees == '0
                      || rsp_heading_degrees > chs_pkg::DEG_LAST_SECTOR))
      |-> (rsp_sector_index == chs_pkg::SECTOR_NONE))
      else $error("sector wrong for heading near north");

   a_sector_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_heading_degrees != '0
       && rsp_heading_degrees <= chs_pkg::DEG_LAST_SECTOR)
      |-> (rsp_sector_index < chs_pkg::SECTOR_NONE))
      else $error("sector index out of range for lit heading");
`endif

endmodule

`default_nettype wire
